@@ sv/rcwd_pkg.sv @@
// rcwd_pkg: shared types, codes and helpers for the rc command link watchdog
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package rcwd_pkg;

  localparam int TIMEOUT_WIDTH_DEFAULT = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_DISCONNECT_TMO = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_TMO = 1'b1;

  localparam logic [CFG_DATA_W-1:0] DISCONNECT_TMO_RESET = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] LOST_TMO_RESET = 16'd500;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  localparam logic [7:0] CMD_THROTTLE = 8'h44;
  localparam logic [7:0] CMD_STEERING = 8'h54;

  typedef struct packed {
    logic       operation;
    logic [7:0] command_letter;
    logic [7:0] digit_high;
    logic [7:0] digit_low;
  } item_t;

  typedef struct packed {
    logic       connect_event;
    logic       disconnect_event;
    logic       lost_event;
    logic       throttle_event;
    logic       steering_event;
    logic signed [7:0] throttle_value;
    logic signed [7:0] steering_value;
    logic       link_up;
    logic       driving_now;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } nibble_t;

  // ascii hex digit to nibble, ok low for anything else
  function automatic nibble_t hex_nibble(logic [7:0] c);
    nibble_t n;
    n.ok = 1'b1;
    n.value = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      n.value = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      n.value = c[3:0] + 4'd9;
    end else begin
      n.ok = 1'b0;
    end
    return n;
  endfunction

endpackage

@@ sv/rcwd_cfg_regs.sv @@
// rcwd_cfg_regs: disconnect and lost timeout registers behind the write port
// depends on rcwd_pkg
`timescale 1ns / 1ps

module rcwd_cfg_regs #(
  parameter int TIMEOUT_WIDTH = rcwd_pkg::TIMEOUT_WIDTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rcwd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rcwd_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output logic [TIMEOUT_WIDTH-1:0]            disc_tmo_o,
  output logic [TIMEOUT_WIDTH-1:0]            lost_tmo_o
);

  logic [TIMEOUT_WIDTH-1:0] disc_tmo_q, disc_tmo_d;
  logic [TIMEOUT_WIDTH-1:0] lost_tmo_q, lost_tmo_d;

  always_comb begin
    disc_tmo_d = disc_tmo_q;
    lost_tmo_d = lost_tmo_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        rcwd_pkg::REG_DISCONNECT_TMO: disc_tmo_d = TIMEOUT_WIDTH'(cfg_wdata_i);
        rcwd_pkg::REG_LOST_TMO:       lost_tmo_d = TIMEOUT_WIDTH'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disc_tmo_q <= TIMEOUT_WIDTH'(rcwd_pkg::DISCONNECT_TMO_RESET);
      lost_tmo_q <= TIMEOUT_WIDTH'(rcwd_pkg::LOST_TMO_RESET);
    end else begin
      disc_tmo_q <= disc_tmo_d;
      lost_tmo_q <= lost_tmo_d;
    end
  end

  assign disc_tmo_o = disc_tmo_q;
  assign lost_tmo_o = lost_tmo_q;

endmodule

@@ sv/rcwd_core.sv @@
// rcwd_core: link and drive state, counters and per-request result logic
// depends on rcwd_pkg; state advances when the request is taken
`timescale 1ns / 1ps

module rcwd_core #(
  parameter int TIMEOUT_WIDTH = rcwd_pkg::TIMEOUT_WIDTH_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  rcwd_pkg::item_t           item_i,
  input  logic [TIMEOUT_WIDTH-1:0]  disc_tmo_i,
  input  logic [TIMEOUT_WIDTH-1:0]  lost_tmo_i,
  output rcwd_pkg::result_t         result_o
);

  localparam int CNT_W = TIMEOUT_WIDTH + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  logic             conn_q, conn_d;
  logic             drive_q, drive_d;
  logic [CNT_W-1:0] cmd_cnt_q, cmd_cnt_d;
  logic [CNT_W-1:0] drv_cnt_q, drv_cnt_d;
  logic [7:0]       thr_q, thr_d;
  logic [7:0]       str_q, str_d;

  rcwd_pkg::nibble_t hi_nib, lo_nib;
  logic             is_thr, is_str, digits_ok;
  logic [CNT_W-1:0] cmd_inc, drv_inc;

  assign hi_nib = rcwd_pkg::hex_nibble(item_i.digit_high);
  assign lo_nib = rcwd_pkg::hex_nibble(item_i.digit_low);
  assign digits_ok = hi_nib.ok & lo_nib.ok;
  assign is_thr = (item_i.command_letter == rcwd_pkg::CMD_THROTTLE);
  assign is_str = (item_i.command_letter == rcwd_pkg::CMD_STEERING);
  assign cmd_inc = (cmd_cnt_q == CNT_MAX) ? CNT_MAX : cmd_cnt_q + CNT_W'(1);
  assign drv_inc = (drv_cnt_q == CNT_MAX) ? CNT_MAX : drv_cnt_q + CNT_W'(1);

  always_comb begin
    conn_d = conn_q;
    drive_d = drive_q;
    cmd_cnt_d = cmd_cnt_q;
    drv_cnt_d = drv_cnt_q;
    thr_d = thr_q;
    str_d = str_q;
    result_o = '0;
    if (item_i.operation == rcwd_pkg::OP_COMMAND) begin
      result_o.connect_event = !conn_q;
      conn_d = 1'b1;
      cmd_cnt_d = '0;
      if ((is_thr || is_str) && digits_ok) begin
        if (is_thr) begin
          thr_d = {hi_nib.value, lo_nib.value};
          result_o.throttle_event = 1'b1;
        end else begin
          str_d = {hi_nib.value, lo_nib.value};
          result_o.steering_event = 1'b1;
        end
        drive_d = (thr_d != 8'd0) || (str_d != 8'd0);
        if (drive_d) begin
          drv_cnt_d = '0;
        end
      end
    end else begin
      cmd_cnt_d = cmd_inc;
      drv_cnt_d = drv_inc;
      if (conn_q && (cmd_inc > {1'b0, disc_tmo_i})) begin
        conn_d = 1'b0;
        result_o.disconnect_event = 1'b1;
      end
      if (drive_q && (drv_inc > {1'b0, lost_tmo_i})) begin
        drive_d = 1'b0;
        result_o.lost_event = 1'b1;
      end
    end
    result_o.throttle_value = thr_d;
    result_o.steering_value = str_d;
    result_o.link_up = conn_d;
    result_o.driving_now = drive_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_q <= 1'b0;
      drive_q <= 1'b0;
      cmd_cnt_q <= '0;
      drv_cnt_q <= '0;
      thr_q <= 8'd0;
      str_q <= 8'd0;
    end else if (step_i) begin
      conn_q <= conn_d;
      drive_q <= drive_d;
      cmd_cnt_q <= cmd_cnt_d;
      drv_cnt_q <= drv_cnt_d;
      thr_q <= thr_d;
      str_q <= str_d;
    end
  end

endmodule

@@ sv/rc_command_link_watchdog.sv @@
// rc_command_link_watchdog: top level, input and result registers around the core
// depends on rcwd_pkg, rcwd_cfg_regs and rcwd_core
//
//   channel  dir  handshake                     payload
//   s_axis   in   s_axis_tvalid/s_axis_tready   tdata 24b, tuser 1b (operation)
//   m_axis   out  m_axis_tvalid/m_axis_tready   tdata 24b result
//   cfg      in   cfg_we_i                      cfg_idx_i, cfg_wdata_i 16b
//
// one request per cycle sustained while m_axis_tready holds; a request sits in the input
// register, goes through the core state update and lands in the result register
// result valid once it is in the result register, taken by the receiver at the earliest on the next edge
// a stalled result holds the result register; the input register keeps taking
// requests until it too is full, then s_axis_tready drops
// reset clears the flags, counters and stored values and loads the default timeouts
`timescale 1ns / 1ps

module rc_command_link_watchdog #(
  parameter int TIMEOUT_WIDTH = rcwd_pkg::TIMEOUT_WIDTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] command_letter, [15:8] digit_high, [23:16] digit_low
  input  logic [rcwd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [0] operation
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] connect_event, [1] disconnect_event, [2] lost_event,
  // [3] throttle_event, [4] steering_event, [12:5] throttle_value,
  // [20:13] steering_value, [21] link_up, [22] driving_now, [23] zero
  output logic [rcwd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [rcwd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rcwd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  logic                     in_vld_q;
  rcwd_pkg::item_t          in_item_q;
  logic                     out_vld_q;
  rcwd_pkg::result_t        out_res_q;
  rcwd_pkg::result_t        core_res;
  logic                     out_free, step;
  logic [TIMEOUT_WIDTH-1:0] disc_tmo, lost_tmo;

  assign out_free = !out_vld_q || m_axis_tready;
  assign step = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;

  rcwd_cfg_regs #(
    .TIMEOUT_WIDTH(TIMEOUT_WIDTH)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .disc_tmo_o (disc_tmo),
    .lost_tmo_o (lost_tmo)
  );

  rcwd_core #(
    .TIMEOUT_WIDTH(TIMEOUT_WIDTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (in_item_q),
    .disc_tmo_i(disc_tmo),
    .lost_tmo_i(lost_tmo),
    .result_o  (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.operation <= s_axis_tuser;
      in_item_q.command_letter <= s_axis_tdata[7:0];
      in_item_q.digit_high <= s_axis_tdata[15:8];
      in_item_q.digit_low <= s_axis_tdata[23:16];
    end
    if (step) begin
      out_res_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata = {1'b0,
                         out_res_q.driving_now,
                         out_res_q.link_up,
                         out_res_q.steering_value,
                         out_res_q.throttle_value,
                         out_res_q.steering_event,
                         out_res_q.throttle_event,
                         out_res_q.lost_event,
                         out_res_q.disconnect_event,
                         out_res_q.connect_event};

endmodule
